// ===== sv/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
// No dependencies; expands to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define NBDP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("nbdp assertion failed");
`define NBDP_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("nbdp reset assertion failed");
`else
`define NBDP_ASSERT(lbl, prop)
`define NBDP_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== sv/nbdp_pkg.sv =====
// Constants for the naive Bayes detection posterior block.
// No dependencies.
package nbdp_pkg;

  localparam logic [2:0] OP_CLASSIFY   = 3'd0;
  localparam logic [2:0] OP_LOAD_X     = 3'd1;
  localparam logic [2:0] OP_LOAD_Y     = 3'd2;
  localparam logic [2:0] OP_LOAD_LEVEL = 3'd3;
  localparam logic [2:0] OP_LOAD_CONF  = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_LEVEL  = 2'd1;
  localparam logic [1:0] ST_MISS_ZERO = 2'd2;
  localparam logic [1:0] ST_BAD_INDEX = 2'd3;

  localparam logic [2:0] MODE_ALL          = 3'd0;
  localparam logic [2:0] MODE_CONF         = 3'd1;
  localparam logic [2:0] MODE_CONF_SCALE   = 3'd2;
  localparam logic [2:0] MODE_CONF_SCALE_X = 3'd3;
  localparam logic [2:0] MODE_CONF_X       = 3'd4;

  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_X_BIN_COUNT  = 3'd2;
  localparam logic [2:0] REG_Y_BIN_COUNT  = 3'd3;
  localparam logic [2:0] REG_CONF_BIN_CNT = 3'd4;
  localparam logic [2:0] REG_PRIOR_HIT    = 3'd5;
  localparam logic [2:0] REG_PRIOR_MISS   = 3'd6;
  localparam logic [2:0] REG_FEATURE_MODE = 3'd7;

  localparam int DIV_W           = 82;
  localparam int QUOT_W          = 16;
  localparam int DIV_STEPS       = 2;
  localparam int DIV_STAGES      = QUOT_W / DIV_STEPS;

endpackage

// ===== sv/nbdp_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module nbdp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/naive_bayes_detection_posterior.sv =====
// Top level of the naive Bayes detection posterior block.
// Depends on nbdp_pkg, nbdp_ram and assert_macros.svh.
//  s_* carries one item per beat: tuser is the opcode, tdata holds the
//  detection fields or a table entry to load. m_* returns one result per
//  input beat, in order: tdata is the Q0.16 hit posterior, tuser the status.
//  cfg_we/cfg_addr/cfg_data write the registers; write only while idle.
//  Throughput: one beat per cycle unless the output stalls; every stage
//  is a register with a valid bit, and the whole pipe advances together.
//  X and y bin indexes come from a multiply stage and a 7-step divider
//  of compare-subtract steps over two stages, the confidence bin index
//  from the top bits of its product; tables are read from RAM one stage
//  later. The posterior is formed by three multiply stages, a sum stage,
//  and a 16-bit restoring divider at two quotient bits per stage.
//  Loads write the tables in the same stage that classify items read them,
//  so a classify right after a load sees the new entry.
//  Reset clears the pipe, registers and all table valid bits (tables read
//  as zero until loaded); no clearing pass is needed.
//  When m_tready is low with a result waiting, the pipe holds and s_tready
//  drops; nothing is lost or repeated.
module naive_bayes_detection_posterior #(
  parameter int MAX_X_BINS       = 64,
  parameter int MAX_Y_BINS       = 64,
  parameter int MAX_SCALE_LEVELS = 16,
  parameter int MAX_CONF_BINS    = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // x_position, y_position, scale_key, confidence, entry_index, hit_value,
  // miss_value, 2 zero bits
  input  logic [95:0] s_tdata,
  // opcode
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // posterior
  output logic [15:0] m_tdata,
  // status
  output logic [1:0]  m_tuser,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_data
);

  localparam int XAW = (MAX_X_BINS > 1) ? $clog2(MAX_X_BINS) : 1;
  localparam int YAW = (MAX_Y_BINS > 1) ? $clog2(MAX_Y_BINS) : 1;
  localparam int CAW = (MAX_CONF_BINS > 1) ? $clog2(MAX_CONF_BINS) : 1;
  localparam int LAW = (MAX_SCALE_LEVELS > 1) ? $clog2(MAX_SCALE_LEVELS) : 1;
  localparam int DW  = nbdp_pkg::DIV_W;
  localparam int NDS = nbdp_pkg::DIV_STAGES;

  function automatic logic [6:0] clamp_count(logic [6:0] n, int depth);
    if (n == 7'd0) return 7'd1;
    if (int'(n) > depth) return 7'(depth);
    return n;
  endfunction

  function automatic logic [20:0] div_step(logic [19:0] r, logic [12:0] w, int k);
    logic [19:0] d;
    d = 20'(w) << k;
    if (r >= d) return {1'b1, r - d};
    return {1'b0, r};
  endfunction

  // configuration
  logic [12:0] image_width, image_height;
  logic [6:0]  x_bin_count, y_bin_count, conf_bin_count;
  logic [15:0] prior_hit, prior_miss;
  logic [2:0]  feature_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= 13'd640;
      image_height   <= 13'd480;
      x_bin_count    <= 7'd64;
      y_bin_count    <= 7'd64;
      conf_bin_count <= 7'd64;
      prior_hit      <= 16'd32768;
      prior_miss     <= 16'd32768;
      feature_mode   <= nbdp_pkg::MODE_ALL;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        nbdp_pkg::REG_IMAGE_WIDTH:  image_width    <= cfg_data[12:0];
        nbdp_pkg::REG_IMAGE_HEIGHT: image_height   <= cfg_data[12:0];
        nbdp_pkg::REG_X_BIN_COUNT:  x_bin_count    <= cfg_data[6:0];
        nbdp_pkg::REG_Y_BIN_COUNT:  y_bin_count    <= cfg_data[6:0];
        nbdp_pkg::REG_CONF_BIN_CNT: conf_bin_count <= cfg_data[6:0];
        nbdp_pkg::REG_PRIOR_HIT:    prior_hit      <= cfg_data;
        nbdp_pkg::REG_PRIOR_MISS:   prior_miss     <= cfg_data;
        nbdp_pkg::REG_FEATURE_MODE: feature_mode   <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  logic [6:0] nx, ny, nc;
  assign nx = clamp_count(x_bin_count, MAX_X_BINS);
  assign ny = clamp_count(y_bin_count, MAX_Y_BINS);
  assign nc = clamp_count(conf_bin_count, MAX_CONF_BINS);

  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // stage 1: capture, bin products
  logic        v1, xover1, yover1;
  logic [2:0]  op1;
  logic [15:0] key1, hv1, mv1;
  logic [5:0]  idx1;
  logic [18:0] xn1, yn1;
  logic [22:0] cn1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= s_tvalid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op1    <= s_tuser;
      key1   <= s_tdata[39:24];
      idx1   <= s_tdata[61:56];
      hv1    <= s_tdata[77:62];
      mv1    <= s_tdata[93:78];
      xn1    <= 19'(s_tdata[11:0]) * 19'(nx);
      yn1    <= 19'(s_tdata[23:12]) * 19'(ny);
      cn1    <= 23'(s_tdata[55:40]) * 23'(nc);
      xover1 <= {1'b0, s_tdata[11:0]} >= image_width;
      yover1 <= {1'b0, s_tdata[23:12]} >= image_height;
    end
  end

  // stage 2: upper quotient bits
  logic        v2, xover2, yover2;
  logic [2:0]  op2;
  logic [15:0] key2, hv2, mv2;
  logic [5:0]  idx2;
  logic [19:0] xr2, yr2, xr_c2, yr_c2;
  logic [6:0]  xq2, yq2, xq_c2, yq_c2, ci2, cp_c2;
  logic [20:0] tx2, ty2;

  always_comb begin
    xr_c2 = 20'(xn1);
    yr_c2 = 20'(yn1);
    xq_c2 = '0;
    yq_c2 = '0;
    for (int k = 6; k >= 3; k--) begin
      tx2 = div_step(xr_c2, image_width, k);
      ty2 = div_step(yr_c2, image_height, k);
      xq_c2[k] = tx2[20];
      yq_c2[k] = ty2[20];
      xr_c2 = tx2[19:0];
      yr_c2 = ty2[19:0];
    end
    cp_c2 = cn1[22:16];
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op2    <= op1;
      key2   <= key1;
      idx2   <= idx1;
      hv2    <= hv1;
      mv2    <= mv1;
      xr2    <= xr_c2;
      yr2    <= yr_c2;
      xq2    <= xq_c2;
      yq2    <= yq_c2;
      xover2 <= xover1;
      yover2 <= yover1;
      ci2    <= (cp_c2 >= nc) ? nc - 7'd1 : cp_c2;
    end
  end

  // stage 3: lower quotient bits, table access
  logic        v3;
  logic [2:0]  op3;
  logic [15:0] key3, hv3, mv3;
  logic [5:0]  idx3;
  logic [XAW-1:0] xi3;
  logic [YAW-1:0] yi3;
  logic [CAW-1:0] ci3;
  logic [19:0] xr_c3, yr_c3;
  logic [6:0]  xq_c3, yq_c3, xi_c3, yi_c3;
  logic [20:0] tx3, ty3;

  always_comb begin
    xr_c3 = xr2;
    yr_c3 = yr2;
    xq_c3 = xq2;
    yq_c3 = yq2;
    for (int k = 2; k >= 0; k--) begin
      tx3 = div_step(xr_c3, image_width, k);
      ty3 = div_step(yr_c3, image_height, k);
      xq_c3[k] = tx3[20];
      yq_c3[k] = ty3[20];
      xr_c3 = tx3[19:0];
      yr_c3 = ty3[19:0];
    end
    xi_c3 = (xover2 || xq_c3 >= nx) ? nx - 7'd1 : xq_c3;
    yi_c3 = (yover2 || yq_c3 >= ny) ? ny - 7'd1 : yq_c3;
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op3  <= op2;
      key3 <= key2;
      idx3 <= idx2;
      hv3  <= hv2;
      mv3  <= mv2;
      xi3  <= XAW'(xi_c3);
      yi3  <= YAW'(yi_c3);
      ci3  <= CAW'(ci2);
    end
  end

  logic ok_x3, ok_y3, ok_c3, ok_l3, bad3;
  logic x_we, y_we, c_we, l_we;
  assign ok_x3 = int'(idx3) < MAX_X_BINS;
  assign ok_y3 = int'(idx3) < MAX_Y_BINS;
  assign ok_c3 = int'(idx3) < MAX_CONF_BINS;
  assign ok_l3 = int'(idx3) < MAX_SCALE_LEVELS;
  assign x_we  = adv && v3 && op3 == nbdp_pkg::OP_LOAD_X && ok_x3;
  assign y_we  = adv && v3 && op3 == nbdp_pkg::OP_LOAD_Y && ok_y3;
  assign c_we  = adv && v3 && op3 == nbdp_pkg::OP_LOAD_CONF && ok_c3;
  assign l_we  = adv && v3 && op3 == nbdp_pkg::OP_LOAD_LEVEL && ok_l3;

  always_comb begin
    case (op3)
      nbdp_pkg::OP_LOAD_X:     bad3 = !ok_x3;
      nbdp_pkg::OP_LOAD_Y:     bad3 = !ok_y3;
      nbdp_pkg::OP_LOAD_LEVEL: bad3 = !ok_l3;
      nbdp_pkg::OP_LOAD_CONF:  bad3 = !ok_c3;
      default:                 bad3 = 1'b0;
    endcase
  end

  logic [31:0] x_rd, y_rd, c_rd;

  nbdp_ram #(.WIDTH(32), .DEPTH(MAX_X_BINS)) u_x_ram (
    .clk(clk), .we(x_we), .waddr(XAW'(idx3)), .wdata({hv3, mv3}),
    .re(adv), .raddr(xi3), .rdata(x_rd)
  );
  nbdp_ram #(.WIDTH(32), .DEPTH(MAX_Y_BINS)) u_y_ram (
    .clk(clk), .we(y_we), .waddr(YAW'(idx3)), .wdata({hv3, mv3}),
    .re(adv), .raddr(yi3), .rdata(y_rd)
  );
  nbdp_ram #(.WIDTH(32), .DEPTH(MAX_CONF_BINS)) u_c_ram (
    .clk(clk), .we(c_we), .waddr(CAW'(idx3)), .wdata({hv3, mv3}),
    .re(adv), .raddr(ci3), .rdata(c_rd)
  );

  logic x_vld [MAX_X_BINS];
  logic y_vld [MAX_Y_BINS];
  logic c_vld [MAX_CONF_BINS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_X_BINS; i++) x_vld[i] <= 1'b0;
      for (int i = 0; i < MAX_Y_BINS; i++) y_vld[i] <= 1'b0;
      for (int i = 0; i < MAX_CONF_BINS; i++) c_vld[i] <= 1'b0;
    end else begin
      if (x_we) x_vld[XAW'(idx3)] <= 1'b1;
      if (y_we) y_vld[YAW'(idx3)] <= 1'b1;
      if (c_we) c_vld[CAW'(idx3)] <= 1'b1;
    end
  end

  // scale levels
  logic [15:0] lvl_key  [MAX_SCALE_LEVELS];
  logic [15:0] lvl_hit  [MAX_SCALE_LEVELS];
  logic [15:0] lvl_miss [MAX_SCALE_LEVELS];
  logic        lvl_vld  [MAX_SCALE_LEVELS];
  logic           lfound;
  logic [LAW-1:0] lidx;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_SCALE_LEVELS; i++) lvl_vld[i] <= 1'b0;
    end else if (l_we) begin
      lvl_vld[LAW'(idx3)] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (l_we) begin
      lvl_key[LAW'(idx3)]  <= key3;
      lvl_hit[LAW'(idx3)]  <= hv3;
      lvl_miss[LAW'(idx3)] <= mv3;
    end
  end

  always_comb begin
    lfound = 1'b0;
    lidx   = '0;
    for (int i = MAX_SCALE_LEVELS - 1; i >= 0; i--) begin
      if (lvl_vld[i] && lvl_key[i] == key3) begin
        lfound = 1'b1;
        lidx   = LAW'(i);
      end
    end
  end

  // stage 4: table data, status, factor selection
  logic        v4, bad4, found4, xv4, yv4, cv4;
  logic [2:0]  op4;
  logic [15:0] zh4, zm4;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op4    <= op3;
      bad4   <= bad3;
      found4 <= lfound;
      zh4    <= lvl_hit[lidx];
      zm4    <= lvl_miss[lidx];
      xv4    <= x_vld[xi3];
      yv4    <= y_vld[yi3];
      cv4    <= c_vld[ci3];
    end
  end

  logic [1:0]  st4;
  logic        calc4, use_z, use_x, use_y;
  logic [15:0] xh4, xm4, yh4, ym4, ch4, cm4;

  always_comb begin
    st4 = nbdp_pkg::ST_OK;
    if (op4 == nbdp_pkg::OP_CLASSIFY) begin
      if (!found4) st4 = nbdp_pkg::ST_NO_LEVEL;
      else if (zm4 == 16'd0) st4 = nbdp_pkg::ST_MISS_ZERO;
    end else if (bad4) begin
      st4 = nbdp_pkg::ST_BAD_INDEX;
    end
    calc4 = op4 == nbdp_pkg::OP_CLASSIFY && st4 == nbdp_pkg::ST_OK;
    use_z = feature_mode != nbdp_pkg::MODE_CONF && feature_mode != nbdp_pkg::MODE_CONF_X;
    use_x = feature_mode != nbdp_pkg::MODE_CONF
            && feature_mode != nbdp_pkg::MODE_CONF_SCALE;
    use_y = feature_mode == nbdp_pkg::MODE_ALL || feature_mode > nbdp_pkg::MODE_CONF_X;
    ch4 = cv4 ? c_rd[31:16] : 16'd0;
    cm4 = cv4 ? c_rd[15:0] : 16'd0;
    xh4 = !use_x ? 16'd1 : (xv4 ? x_rd[31:16] : 16'd0);
    xm4 = !use_x ? 16'd1 : (xv4 ? x_rd[15:0] : 16'd0);
    yh4 = !use_y ? 16'd1 : (yv4 ? y_rd[31:16] : 16'd0);
    ym4 = !use_y ? 16'd1 : (yv4 ? y_rd[15:0] : 16'd0);
  end

  // stages 5-7: products
  logic        v5, v6, v7, calc5, calc6, calc7;
  logic [1:0]  st5, st6, st7;
  logic [31:0] ah5, bh5, am5, bm5;
  logic [15:0] yh5, ym5, yh6, ym6;
  logic [63:0] ch6, cm6;
  logic [79:0] h7, m7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st5   <= st4;
      calc5 <= calc4;
      ah5   <= 32'(prior_hit) * 32'(ch4);
      am5   <= 32'(prior_miss) * 32'(cm4);
      bh5   <= 32'(use_z ? zh4 : 16'd1) * 32'(xh4);
      bm5   <= 32'(use_z ? zm4 : 16'd1) * 32'(xm4);
      yh5   <= yh4;
      ym5   <= ym4;
      st6   <= st5;
      calc6 <= calc5;
      ch6   <= 64'(ah5) * 64'(bh5);
      cm6   <= 64'(am5) * 64'(bm5);
      yh6   <= yh5;
      ym6   <= ym5;
      st7   <= st6;
      calc7 <= calc6;
      h7    <= 80'(ch6) * 80'(yh6);
      m7    <= 80'(cm6) * 80'(ym6);
    end
  end

  // stage 8 and divider stages: floor(H * 2^16 / (H + M))
  logic              dv    [NDS+1];
  logic [1:0]        dst   [NDS+1];
  logic              dcalc [NDS+1];
  logic              dsz   [NDS+1];
  logic              dmz   [NDS+1];
  logic [DW-1:0]     drem  [NDS+1];
  logic [DW-1:0]     dsum  [NDS+1];
  logic [15:0]       dq    [NDS+1];

  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else if (adv) dv[0] <= v7;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dst[0]   <= st7;
      dcalc[0] <= calc7;
      dsz[0]   <= h7 == '0 && m7 == '0;
      dmz[0]   <= m7 == '0;
      drem[0]  <= DW'(h7);
      dsum[0]  <= DW'(h7) + DW'(m7);
      dq[0]    <= '0;
    end
  end

  for (genvar g = 1; g <= NDS; g++) begin : g_div
    logic [DW-1:0] r_n;
    logic [15:0]   q_n;

    always_comb begin
      r_n = drem[g-1];
      q_n = dq[g-1];
      for (int k = 0; k < nbdp_pkg::DIV_STEPS; k++) begin
        r_n = r_n << 1;
        q_n = {q_n[14:0], 1'b0};
        if (r_n >= dsum[g-1]) begin
          r_n    = r_n - dsum[g-1];
          q_n[0] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) dv[g] <= 1'b0;
      else if (adv) dv[g] <= dv[g-1];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dst[g]   <= dst[g-1];
        dcalc[g] <= dcalc[g-1];
        dsz[g]   <= dsz[g-1];
        dmz[g]   <= dmz[g-1];
        drem[g]  <= r_n;
        dsum[g]  <= dsum[g-1];
        dq[g]    <= q_n;
      end
    end
  end

  // output register
  logic [15:0] post_c;

  always_comb begin
    if (!dcalc[NDS] || dsz[NDS]) post_c = 16'd0;
    else if (dmz[NDS]) post_c = 16'hFFFF;
    else post_c = dq[NDS];
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (adv) m_tvalid <= dv[NDS];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= post_c;
      m_tuser <= dst[NDS];
    end
  end

`include "assert_macros.svh"

  `NBDP_ASSERT_RST(a_reset_empty, rst |=> !m_tvalid)
  `NBDP_ASSERT(a_err_zero, m_tvalid && m_tuser != nbdp_pkg::ST_OK |-> m_tdata == 16'd0)
  `NBDP_ASSERT(a_stall_hold, !adv |=> $stable(v1) && $stable(v4) && $stable(dv[NDS]))
  `NBDP_ASSERT(a_no_write_stall, !adv |-> !x_we && !y_we && !c_we && !l_we)

endmodule
